/* design/tgbd_pkg.sv */
// Package for the touch grid button debouncer.
// Holds stream widths, register indexes, reset values and the sequencer state type.
// No dependencies.
`default_nettype none

package tgbd_pkg;

    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;

    localparam int S_TDATA_W = 24;   // touch_x[8:0], touch_y[16:9], zero fill
    localparam int M_TDATA_W = 24;   // cell_column[8:0], cell_row[16:9], zero fill

    localparam int COL_W   = 9;
    localparam int ROW_W   = 8;
    localparam int PCNT_W  = 16;
    localparam int RCNT_W  = 8;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 16;

    typedef enum logic [CFG_A_W-1:0] {
        REG_GRID_COLUMNS  = 3'd0,
        REG_GRID_ROWS     = 3'd1,
        REG_PRESS_SAMPLES = 3'd2,
        REG_REL_SAMPLES   = 3'd3,
        REG_LONG_SAMPLES  = 3'd4
    } cfg_reg_t;

    localparam logic [8:0]  GRID_COLUMNS_RST  = 9'd1;
    localparam logic [7:0]  GRID_ROWS_RST     = 8'd1;
    localparam logic [7:0]  PRESS_SAMPLES_RST = 8'd10;
    localparam logic [7:0]  REL_SAMPLES_RST   = 8'd10;
    localparam logic [15:0] LONG_SAMPLES_RST  = 16'd500;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIDE_X,
        ST_CELL_X,
        ST_SIDE_Y,
        ST_CELL_Y,
        ST_UPDATE
    } seq_state_t;

    function automatic int bits_for(input int value);
        int n;
        n = 1;
        while ((1 << n) <= value) n = n + 1;
        return n;
    endfunction

    // Divider width: covers both screen sizes and the 9-bit coordinate field.
    function automatic int div_width(input int sw, input int sh);
        int w;
        w = COL_W;
        if (bits_for(sw) > w) w = bits_for(sw);
        if (bits_for(sh) > w) w = bits_for(sh);
        return w;
    endfunction

endpackage

`default_nettype wire

/* design/tgbd_divider.sv */
// Shared restoring divider, one quotient bit per cycle.
// Used by the debouncer sequencer for cell side and cell index; uses tgbd_pkg.
`default_nettype none

module tgbd_divider
    import tgbd_pkg::*;
#(
    parameter int DIV_W = COL_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DIV_W-1:0] divisor,   // never zero
    output logic                  done,
    output logic      [DIV_W-1:0] quotient
);

    localparam int CNT_W = bits_for(DIV_W);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        diff      = trial - {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(DIV_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ~diff[DIV_W]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            den_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* design/touch_grid_button_debouncer_unit.sv */
// Touch grid button debouncer, top level.
// Uses tgbd_pkg and tgbd_divider.
//
// Usage:
//   s_ channel: one touch sample per transfer. s_tuser = touch_present,
//   s_tdata = touch_x[8:0], touch_y[16:9].
//   m_ channel: one debounced button event per accepted release.
//   m_tdata = cell_column[8:0], cell_row[16:9]; m_tuser = long_press.
//   cfg port: cfg_wr_en/cfg_addr/cfg_wdata write one register per cycle;
//   the user must write only while the block is idle; the block does not enforce it.
// Sequencing:
//   An absent sample goes straight to the update step. A present sample
//   first runs four divisions, column side, column, row side, row, each
//   one bit per cycle on the single divider, then the update step.
//   s_tready is high only while the sequencer is idle.
//   A result is registered in the output stage; the next sample is taken
//   while it waits. If a second result is ready before the first is taken,
//   the sequencer holds in its update step until the output stage frees.
// Reset: aresetn is synchronous, active low; counters, phase and config
//   return to their defaults and m_tvalid drops.
`default_nettype none

module touch_grid_button_debouncer_unit
    import tgbd_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // touch_x[8:0], touch_y[16:9]
    input  wire logic                 s_tuser,   // touch_present
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // cell_column[8:0], cell_row[16:9]
    output logic                      m_tuser,   // long_press
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_A_W-1:0]   cfg_addr,
    input  wire logic [CFG_D_W-1:0]   cfg_wdata
);

    localparam int DIV_W = div_width(SCREEN_WIDTH, SCREEN_HEIGHT);
    localparam logic [DIV_W-1:0] SW_C = DIV_W'(SCREEN_WIDTH);
    localparam logic [DIV_W-1:0] SH_C = DIV_W'(SCREEN_HEIGHT);

    // configuration
    logic [COL_W-1:0]  grid_columns_reg;
    logic [ROW_W-1:0]  grid_rows_reg;
    logic [7:0]        press_samples_reg;
    logic [7:0]        rel_samples_reg;
    logic [15:0]       long_samples_reg;

    // sequencer and sample
    seq_state_t        state_reg, state_next;
    logic              present_reg;
    logic [COL_W-1:0]  x_reg;
    logic [ROW_W-1:0]  y_reg;

    // debounce state
    logic              rel_phase_reg, rel_phase_next;
    logic [PCNT_W-1:0] pcnt_reg, pcnt_next, pcnt_inc;
    logic [RCNT_W-1:0] rcnt_reg, rcnt_next, rcnt_inc;
    logic [COL_W-1:0]  held_col_reg;
    logic [ROW_W-1:0]  held_row_reg;
    logic              emit;
    logic              commit;
    logic [7:0]        press_min;
    logic [7:0]        rel_min;

    // output stage
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 out_free;

    // divider
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;
    logic [DIV_W-1:0] quot_min;
    logic [COL_W-1:0] cols_min;
    logic [ROW_W-1:0] rows_min;

    tgbd_divider #(
        .DIV_W (DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_columns_reg  <= GRID_COLUMNS_RST;
            grid_rows_reg     <= GRID_ROWS_RST;
            press_samples_reg <= PRESS_SAMPLES_RST;
            rel_samples_reg   <= REL_SAMPLES_RST;
            long_samples_reg  <= LONG_SAMPLES_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_GRID_COLUMNS:  grid_columns_reg  <= cfg_wdata[COL_W-1:0];
                REG_GRID_ROWS:     grid_rows_reg     <= cfg_wdata[ROW_W-1:0];
                REG_PRESS_SAMPLES: press_samples_reg <= cfg_wdata[7:0];
                REG_REL_SAMPLES:   rel_samples_reg   <= cfg_wdata[7:0];
                REG_LONG_SAMPLES:  long_samples_reg  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign out_free  = !m_tvalid_reg || m_tready;
    assign press_min = (press_samples_reg == '0) ? 8'd1 : press_samples_reg;
    assign rel_min   = (rel_samples_reg == '0) ? 8'd1 : rel_samples_reg;
    assign cols_min  = (grid_columns_reg == '0) ? COL_W'(1) : grid_columns_reg;
    assign rows_min  = (grid_rows_reg == '0) ? ROW_W'(1) : grid_rows_reg;
    assign quot_min  = (div_quot == '0) ? DIV_W'(1) : div_quot;
    assign pcnt_inc  = (pcnt_reg == '1) ? pcnt_reg : pcnt_reg + 1'b1;
    assign rcnt_inc  = (rcnt_reg == '1) ? rcnt_reg : rcnt_reg + 1'b1;

    // debounce update for the current sample
    always_comb begin
        rel_phase_next = rel_phase_reg;
        pcnt_next      = pcnt_reg;
        rcnt_next      = rcnt_reg;
        emit           = 1'b0;
        if (!rel_phase_reg) begin
            pcnt_next = present_reg ? pcnt_inc : '0;
            if (pcnt_next >= {8'd0, press_min}) begin
                rel_phase_next = 1'b1;
                rcnt_next      = '0;
            end
        end else if (present_reg) begin
            rcnt_next = '0;
            pcnt_next = pcnt_inc;
        end else begin
            rcnt_next = rcnt_inc;
            if (rcnt_next >= rel_min) begin
                emit           = 1'b1;
                rel_phase_next = 1'b0;
                pcnt_next      = '0;
                rcnt_next      = '0;
            end
        end
    end

    assign commit = (state_reg == ST_UPDATE) && (!emit || out_free);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = s_tuser ? ST_SIDE_X : ST_UPDATE;
            end
            ST_SIDE_X: if (div_done) state_next = ST_CELL_X;
            ST_CELL_X: if (div_done) state_next = ST_SIDE_Y;
            ST_SIDE_Y: if (div_done) state_next = ST_CELL_Y;
            ST_CELL_Y: if (div_done) state_next = ST_UPDATE;
            ST_UPDATE: if (commit)   state_next = ST_IDLE;
            default:                 state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready     = (state_reg == ST_IDLE);
        div_start    = (state_next != state_reg) &&
                       (state_next inside {ST_SIDE_X, ST_CELL_X, ST_SIDE_Y, ST_CELL_Y});
        div_dividend = SW_C;
        div_divisor  = DIV_W'(cols_min);
        case (state_next)
            ST_SIDE_X: begin
                div_dividend = SW_C;
                div_divisor  = DIV_W'(cols_min);
            end
            ST_CELL_X: begin
                div_dividend = DIV_W'(x_reg);
                div_divisor  = quot_min;
            end
            ST_SIDE_Y: begin
                div_dividend = SH_C;
                div_divisor  = DIV_W'(rows_min);
            end
            ST_CELL_Y: begin
                div_dividend = DIV_W'(y_reg);
                div_divisor  = quot_min;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rel_phase_reg <= 1'b0;
            pcnt_reg      <= '0;
            rcnt_reg      <= '0;
            held_col_reg  <= '0;
            held_row_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                rel_phase_reg <= rel_phase_next;
                pcnt_reg      <= pcnt_next;
                rcnt_reg      <= rcnt_next;
            end
            if (state_reg == ST_CELL_X && div_done) held_col_reg <= div_quot[COL_W-1:0];
            if (state_reg == ST_CELL_Y && div_done) held_row_reg <= div_quot[ROW_W-1:0];
            if (commit && emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (s_tvalid && s_tready) begin
            present_reg <= s_tuser;
            x_reg       <= s_tdata[COL_W-1:0];
            y_reg       <= s_tdata[COL_W+ROW_W-1:COL_W];
        end
        if (commit && emit) begin
            m_tdata_reg <= {{(M_TDATA_W-COL_W-ROW_W){1'b0}}, held_row_reg, held_col_reg};
            m_tuser_reg <= (pcnt_reg > long_samples_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

/* design/tgbd_checker.sv */
// Port-level checker for the touch grid button debouncer, bound to the top level.
// Uses tgbd_pkg; attaches to touch_grid_button_debouncer_unit.
`default_nettype none

module tgbd_checker
    import tgbd_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // result only leaves on a transfer
    a_out_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("result dropped without transfer");

    // one sample at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample taken while busy");

    // a new result comes from the update step, never from idle
    a_emit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while idle");

endmodule

bind touch_grid_button_debouncer_unit tgbd_checker u_tgbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
